// ===== src/vpa_pkg.sv =====
// vpa_pkg: shared types, constants and state encoding of the variable
// partition allocator. No dependencies.
`timescale 1ns / 1ps

package vpa_pkg;

  localparam int FREE_SLOTS = 16;
  localparam int USED_SLOTS = 16;
  localparam int ADDR_W     = 16;
  localparam int ID_W       = 16;
  localparam int MINREM_W   = 10;
  localparam int POLICY_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FREE_IW = $clog2(FREE_SLOTS);
  localparam int USED_IW = $clog2(USED_SLOTS);
  localparam int USED_CW = $clog2(USED_SLOTS + 1);
  localparam int CNT_W   = (FREE_IW > USED_CW) ? FREE_IW : USED_CW;

  localparam logic [ADDR_W-1:0]   MEM_RESET    = ADDR_W'(1024);
  localparam logic [MINREM_W-1:0] MINREM_RESET = MINREM_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINREM   = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] POL_UNDEF = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_PICK, S_CHECK, S_COMPACT, S_GRANT, S_FIND, S_MERGE, S_FREE
  } state_e;

  typedef struct packed {
    logic            operation;
    logic [15:0]     alloc_units;
    logic [15:0]     target_id;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         process_id;
    logic [15:0]         block_start;
    logic [15:0]         block_size;
    logic                compacted;
  } result_t;

  typedef struct packed {
    logic clear;
    logic step;
  } pick_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } cand_t;

endpackage

// ===== src/vpa_pick.sv =====
// vpa_pick: shared compare unit; one free entry per cycle while
// stepped; keeps the policy's pick, sums free space; needs vpa_pkg.
`timescale 1ns / 1ps

module vpa_pick (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vpa_pkg::pick_ctrl_t             ctrl_i,
  input  vpa_pkg::cand_t                  cand_i,
  input  logic [vpa_pkg::FREE_IW-1:0]     cand_idx_i,
  input  logic [vpa_pkg::ADDR_W-1:0]      req_i,
  input  logic [vpa_pkg::POLICY_W-1:0]    policy_i,
  output logic                            found_o,
  output logic [vpa_pkg::FREE_IW-1:0]     idx_o,
  output logic [vpa_pkg::ADDR_W:0]        total_o
);

  logic                          found_q;
  logic [vpa_pkg::FREE_IW-1:0]   idx_q;
  logic [vpa_pkg::ADDR_W-1:0]    bstart_q, bsize_q;
  logic [vpa_pkg::ADDR_W:0]      total_q;
  logic                          fits, better, take;

  assign fits = cand_i.valid && (cand_i.size >= req_i);

  always_comb begin
    priority if (policy_i == vpa_pkg::POL_BEST) begin
      better = (cand_i.size < bsize_q) ||
               ((cand_i.size == bsize_q) && (cand_i.start < bstart_q));
    end else if (policy_i == vpa_pkg::POL_WORST) begin
      better = (cand_i.size > bsize_q) ||
               ((cand_i.size == bsize_q) && (cand_i.start < bstart_q));
    end else begin
      better = cand_i.start < bstart_q;
    end
  end

  assign take = fits && (!found_q || better);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      total_q <= '0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
      total_q <= '0;
    end else if (ctrl_i.step) begin
      if (take) found_q <= 1'b1;
      if (cand_i.valid) total_q <= total_q + {1'b0, cand_i.size};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && take) begin
      idx_q    <= cand_idx_i;
      bstart_q <= cand_i.start;
      bsize_q  <= cand_i.size;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign total_o = total_q;

endmodule

// ===== src/variable_partition_allocator.sv =====
// variable_partition_allocator: top level, sequencer, free/used tables; uses vpa_pkg, vpa_pick.
// Allocate scans every free entry, then grants or fails; compaction repacks the used
//   blocks and rescans. Release looks up the id in age order (newest first), then scans
//   the free table and merges; an unknown id fails after the lookup; zero size, full or empty table reject at once.
// One transfer at a time, busy_o high while working; next start is taken in the done cycle.
// Async active-low reset: one free block {0, 1024}, no used blocks, id 0; no receiver stall.
`timescale 1ns / 1ps

module variable_partition_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  vpa_pkg::cmd_t                      cmd_i,
  output logic                               busy_o,
  output logic                               done_o,
  output vpa_pkg::result_t                   result_o,
  input  logic                               cfg_we_i,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vpa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int AW = vpa_pkg::ADDR_W;

  // configuration
  logic [AW-1:0]                  mem_size_q;
  logic [vpa_pkg::POLICY_W-1:0]   policy_q;
  logic [vpa_pkg::MINREM_W-1:0]   minrem_q;
  logic                           started_q;

  // free table lives in flops with valid bits; all entries reset, only entry 0 valid
  logic [AW-1:0]                  free_start_q [vpa_pkg::FREE_SLOTS];
  logic [AW-1:0]                  free_size_q  [vpa_pkg::FREE_SLOTS];
  logic [vpa_pkg::FREE_SLOTS-1:0] free_valid_q;

  // used table, undefined until written; age order newest first
  logic [vpa_pkg::ID_W-1:0]       used_id_q    [vpa_pkg::USED_SLOTS];
  logic [AW-1:0]                  used_start_q [vpa_pkg::USED_SLOTS];
  logic [AW-1:0]                  used_size_q  [vpa_pkg::USED_SLOTS];
  logic [vpa_pkg::USED_SLOTS-1:0] used_valid_q;
  logic [vpa_pkg::USED_IW-1:0]    age_q        [vpa_pkg::USED_SLOTS];
  logic [vpa_pkg::USED_CW-1:0]    used_cnt_q;
  logic [vpa_pkg::ID_W-1:0]       id_cnt_q;

  // sequencer
  vpa_pkg::state_e                state_q, state_d;
  logic [vpa_pkg::CNT_W-1:0]      cnt_q;
  logic                           comp_q;
  logic [AW-1:0]                  req_q;
  logic [vpa_pkg::ID_W-1:0]       tid_q;
  logic [AW-1:0]                  nxt_q;

  // release scratch
  logic [vpa_pkg::USED_IW-1:0]    k_q, slot_q;
  logic [AW-1:0]                  rs_q, rz_q, re_q;
  logic                           prev_f_q, next_f_q, empty_f_q;
  logic [vpa_pkg::FREE_IW-1:0]    prev_q, next_q, empty_q;
  logic [AW-1:0]                  prev_size_q, next_size_q;

  vpa_pkg::result_t               result_q;
  logic                           done_q, done_d;

  // shared compare unit
  vpa_pkg::pick_ctrl_t            pick_ctrl;
  vpa_pkg::cand_t                 cand;
  logic                           pick_found;
  logic [vpa_pkg::FREE_IW-1:0]    pick_idx;
  logic [AW:0]                    pick_total;

  // combinational helpers
  logic [vpa_pkg::FREE_IW-1:0]    fidx;
  logic [vpa_pkg::USED_IW-1:0]    uidx, age_at;
  logic                           last_free, last_used, id_hit, compact_done;
  logic [vpa_pkg::ID_W-1:0]       new_id;
  logic                           idle_fail;
  logic [vpa_pkg::STATUS_W-1:0]   idle_status;
  logic                           can_compact;
  logic [AW-1:0]                  g_start, g_size, g_left, g_granted;
  logic                           g_whole;
  logic [vpa_pkg::USED_IW-1:0]    free_slot;
  logic [AW-1:0]                  fend, comp_size;
  logic                           rel_ok;

  assign fidx      = cnt_q[vpa_pkg::FREE_IW-1:0];
  assign uidx      = cnt_q[vpa_pkg::USED_IW-1:0];
  assign age_at    = age_q[uidx];
  assign last_free = (fidx == vpa_pkg::FREE_IW'(vpa_pkg::FREE_SLOTS - 1));
  assign last_used = ((cnt_q + vpa_pkg::CNT_W'(1)) >= vpa_pkg::CNT_W'(used_cnt_q));
  assign id_hit    = (used_id_q[age_at] == tid_q);
  assign compact_done = (cnt_q == vpa_pkg::CNT_W'(used_cnt_q));
  assign new_id    = id_cnt_q + vpa_pkg::ID_W'(1);

  assign cand.valid = free_valid_q[fidx];
  assign cand.start = free_start_q[fidx];
  assign cand.size  = free_size_q[fidx];
  assign fend       = free_start_q[fidx] + free_size_q[fidx];

  // quick rejects decided at the accepting edge
  always_comb begin
    idle_fail   = 1'b0;
    idle_status = vpa_pkg::ST_OK;
    if (cmd_i.operation == vpa_pkg::OP_ALLOC) begin
      if (cmd_i.alloc_units == '0) begin
        idle_fail   = 1'b1;
        idle_status = vpa_pkg::ST_NOSPACE;
      end else if (used_cnt_q == vpa_pkg::USED_CW'(vpa_pkg::USED_SLOTS)) begin
        idle_fail   = 1'b1;
        idle_status = vpa_pkg::ST_FULL;
      end
    end else if (used_cnt_q == '0) begin
      idle_fail   = 1'b1;
      idle_status = vpa_pkg::ST_UNKNOWN;
    end
  end

  assign can_compact = !comp_q && (pick_total >= {1'b0, req_q});

  // grant arithmetic on the chosen free entry
  assign g_start   = free_start_q[pick_idx];
  assign g_size    = free_size_q[pick_idx];
  assign g_left    = g_size - req_q;
  assign g_whole   = g_left <= AW'(minrem_q);
  assign g_granted = g_whole ? g_size : req_q;
  assign comp_size = (mem_size_q >= nxt_q) ? (mem_size_q - nxt_q) : '0;
  assign rel_ok    = prev_f_q || next_f_q || empty_f_q;

  // lowest unused slot
  always_comb begin
    free_slot = '0;
    for (int i = vpa_pkg::USED_SLOTS - 1; i >= 0; i--) begin
      if (!used_valid_q[i]) free_slot = vpa_pkg::USED_IW'(i);
    end
  end

  vpa_pick u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (pick_ctrl),
    .cand_i     (cand),
    .cand_idx_i (fidx),
    .req_i      (req_q),
    .policy_i   (policy_q),
    .found_o    (pick_found),
    .idx_o      (pick_idx),
    .total_o    (pick_total)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vpa_pkg::S_IDLE: begin
        if (start_i && !idle_fail) begin
          state_d = (cmd_i.operation == vpa_pkg::OP_ALLOC) ? vpa_pkg::S_PICK
                                                            : vpa_pkg::S_FIND;
        end
      end
      vpa_pkg::S_PICK:    if (last_free) state_d = vpa_pkg::S_CHECK;
      vpa_pkg::S_CHECK: begin
        if (pick_found)       state_d = vpa_pkg::S_GRANT;
        else if (can_compact) state_d = vpa_pkg::S_COMPACT;
        else                  state_d = vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_COMPACT: if (compact_done) state_d = vpa_pkg::S_PICK;
      vpa_pkg::S_GRANT:   state_d = vpa_pkg::S_IDLE;
      vpa_pkg::S_FIND: begin
        if (id_hit)         state_d = vpa_pkg::S_MERGE;
        else if (last_used) state_d = vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_MERGE:   if (last_free) state_d = vpa_pkg::S_FREE;
      vpa_pkg::S_FREE:    state_d = vpa_pkg::S_IDLE;
      default:            state_d = vpa_pkg::S_IDLE;
    endcase
  end

  // result strobe: quick reject, failed search, grant, unknown id, release
  always_comb begin
    done_d = 1'b0;
    unique case (state_q)
      vpa_pkg::S_IDLE:  done_d = start_i && idle_fail;
      vpa_pkg::S_CHECK: done_d = !pick_found && !can_compact;
      vpa_pkg::S_GRANT: done_d = 1'b1;
      vpa_pkg::S_FIND:  done_d = !id_hit && last_used;
      vpa_pkg::S_FREE:  done_d = 1'b1;
      default:          done_d = 1'b0;
    endcase
  end

  // control toward the compare unit
  always_comb begin
    pick_ctrl.clear = (state_q == vpa_pkg::S_IDLE) ||
                      ((state_q == vpa_pkg::S_COMPACT) && compact_done);
    pick_ctrl.step  = (state_q == vpa_pkg::S_PICK);
  end

  // control state and tables with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q   <= vpa_pkg::MEM_RESET;
      policy_q     <= vpa_pkg::POL_FIRST;
      minrem_q     <= vpa_pkg::MINREM_RESET;
      started_q    <= 1'b0;
      for (int i = 0; i < vpa_pkg::FREE_SLOTS; i++) begin
        free_start_q[i] <= '0;
        free_size_q[i]  <= (i == 0) ? vpa_pkg::MEM_RESET : '0;
      end
      free_valid_q <= vpa_pkg::FREE_SLOTS'(1);
      used_valid_q <= '0;
      used_cnt_q   <= '0;
      id_cnt_q     <= '0;
      state_q      <= vpa_pkg::S_IDLE;
      cnt_q        <= '0;
      comp_q       <= 1'b0;
      prev_f_q     <= 1'b0;
      next_f_q     <= 1'b0;
      empty_f_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q  <= done_d;
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vpa_pkg::CFG_MEM_SIZE: begin
            if (!started_q && (cfg_wdata_i != '0)) begin
              mem_size_q      <= AW'(cfg_wdata_i);
              free_start_q[0] <= '0;
              free_size_q[0]  <= AW'(cfg_wdata_i);
            end
          end
          vpa_pkg::CFG_POLICY: begin
            if (cfg_wdata_i[vpa_pkg::POLICY_W-1:0] != vpa_pkg::POL_UNDEF)
              policy_q <= cfg_wdata_i[vpa_pkg::POLICY_W-1:0];
          end
          vpa_pkg::CFG_MINREM: minrem_q <= cfg_wdata_i[vpa_pkg::MINREM_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        vpa_pkg::S_IDLE: begin
          if (start_i) begin
            started_q <= 1'b1;
            cnt_q     <= '0;
            comp_q    <= 1'b0;
            if (cmd_i.operation == vpa_pkg::OP_ALLOC) id_cnt_q <= new_id;
          end
        end
        vpa_pkg::S_PICK: cnt_q <= last_free ? '0 : cnt_q + vpa_pkg::CNT_W'(1);
        vpa_pkg::S_CHECK: begin
          if (!pick_found && can_compact) begin
            comp_q <= 1'b1;
            cnt_q  <= '0;
          end
        end
        vpa_pkg::S_COMPACT: begin
          if (compact_done) begin
            // everything free collapses into one block behind the packed ones
            free_valid_q    <= vpa_pkg::FREE_SLOTS'(1);
            free_start_q[0] <= nxt_q;
            free_size_q[0]  <= comp_size;
            cnt_q           <= '0;
          end else begin
            cnt_q <= cnt_q + vpa_pkg::CNT_W'(1);
          end
        end
        vpa_pkg::S_GRANT: begin
          if (g_whole) begin
            free_valid_q[pick_idx] <= 1'b0;
          end else begin
            free_start_q[pick_idx] <= g_start + req_q;
            free_size_q[pick_idx]  <= g_left;
          end
          used_valid_q[free_slot] <= 1'b1;
          used_cnt_q <= used_cnt_q + vpa_pkg::USED_CW'(1);
        end
        vpa_pkg::S_FIND: begin
          if (id_hit) begin
            cnt_q     <= '0;
            prev_f_q  <= 1'b0;
            next_f_q  <= 1'b0;
            empty_f_q <= 1'b0;
          end else if (!last_used) begin
            cnt_q <= cnt_q + vpa_pkg::CNT_W'(1);
          end
        end
        vpa_pkg::S_MERGE: begin
          if (!cand.valid) begin
            if (!empty_f_q) empty_f_q <= 1'b1;
          end else if ((fend == rs_q) && !prev_f_q) begin
            prev_f_q <= 1'b1;
          end else if ((cand.start == re_q) && !next_f_q) begin
            next_f_q <= 1'b1;
          end
          cnt_q <= last_free ? '0 : cnt_q + vpa_pkg::CNT_W'(1);
        end
        vpa_pkg::S_FREE: begin
          if (prev_f_q && next_f_q) begin
            free_size_q[prev_q]  <= prev_size_q + rz_q + next_size_q;
            free_valid_q[next_q] <= 1'b0;
          end else if (prev_f_q) begin
            free_size_q[prev_q] <= prev_size_q + rz_q;
          end else if (next_f_q) begin
            free_start_q[next_q] <= rs_q;
            free_size_q[next_q]  <= next_size_q + rz_q;
          end else if (empty_f_q) begin
            free_start_q[empty_q] <= rs_q;
            free_size_q[empty_q]  <= rz_q;
            free_valid_q[empty_q] <= 1'b1;
          end
          if (rel_ok) begin
            used_valid_q[slot_q] <= 1'b0;
            used_cnt_q <= used_cnt_q - vpa_pkg::USED_CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload: used table, age order, scratch and result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vpa_pkg::S_IDLE: begin
        if (start_i) begin
          req_q <= AW'(cmd_i.alloc_units);
          tid_q <= cmd_i.target_id;
          nxt_q <= '0;
          result_q.status      <= idle_status;
          result_q.process_id  <= (cmd_i.operation == vpa_pkg::OP_ALLOC) ? new_id
                                                                          : cmd_i.target_id;
          result_q.block_start <= '0;
          result_q.block_size  <= '0;
          result_q.compacted   <= 1'b0;
        end
      end
      vpa_pkg::S_CHECK: begin
        result_q <= '{status: vpa_pkg::ST_NOSPACE, process_id: id_cnt_q,
                      block_start: '0, block_size: '0, compacted: 1'b0};
      end
      vpa_pkg::S_COMPACT: begin
        // pack newest first from address zero
        if (!compact_done) begin
          used_start_q[age_at] <= nxt_q;
          nxt_q <= nxt_q + used_size_q[age_at];
        end
      end
      vpa_pkg::S_GRANT: begin
        used_id_q[free_slot]    <= id_cnt_q;
        used_start_q[free_slot] <= g_start;
        used_size_q[free_slot]  <= g_granted;
        for (int j = vpa_pkg::USED_SLOTS - 1; j > 0; j--) age_q[j] <= age_q[j-1];
        age_q[0] <= free_slot;
        result_q <= '{status: vpa_pkg::ST_OK, process_id: id_cnt_q,
                      block_start: g_start, block_size: g_granted, compacted: comp_q};
      end
      vpa_pkg::S_FIND: begin
        if (id_hit) begin
          k_q    <= uidx;
          slot_q <= age_at;
          rs_q   <= used_start_q[age_at];
          rz_q   <= used_size_q[age_at];
          re_q   <= used_start_q[age_at] + used_size_q[age_at];
        end
        result_q <= '{status: vpa_pkg::ST_UNKNOWN, process_id: tid_q,
                      block_start: '0, block_size: '0, compacted: 1'b0};
      end
      vpa_pkg::S_MERGE: begin
        if (!cand.valid) begin
          if (!empty_f_q) empty_q <= fidx;
        end else if ((fend == rs_q) && !prev_f_q) begin
          prev_q      <= fidx;
          prev_size_q <= cand.size;
        end else if ((cand.start == re_q) && !next_f_q) begin
          next_q      <= fidx;
          next_size_q <= cand.size;
        end
      end
      vpa_pkg::S_FREE: begin
        if (rel_ok) begin
          for (int j = 0; j < vpa_pkg::USED_SLOTS - 1; j++) begin
            if (vpa_pkg::USED_IW'(j) >= k_q) age_q[j] <= age_q[j+1];
          end
          result_q <= '{status: vpa_pkg::ST_OK, process_id: tid_q,
                        block_start: rs_q, block_size: rz_q, compacted: 1'b0};
        end else begin
          result_q <= '{status: vpa_pkg::ST_FULL, process_id: tid_q,
                        block_start: '0, block_size: '0, compacted: 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign busy_o   = (state_q != vpa_pkg::S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // a result never shows while a transfer is still being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // occupancy count tracks the valid bits of the used table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_valid_q) == 32'(used_cnt_q))
    else $error("used count out of step with valid bits");

  // an accepted transfer either completes at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transfer lost");

  // an ok result only comes out of a transfer that went through the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == vpa_pkg::ST_OK)) |-> $past(busy_o))
    else $error("ok result without work");

endmodule
